// File: rtl/positional_array_list_top_defines.svh
// -----------------------------------------------------------------------------
// Positional array list assertion macros
// Property wrappers clocked on i_clk, disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pal_pkg.sv
// -----------------------------------------------------------------------------
// Positional array list package
// Opcodes, status codes, controller states and chain control type.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pal_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int DEF_CAPACITY = 128;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_LOCATE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_PASS = 1'b1
    } t_state;

    typedef struct packed {
        logic              shift;
        logic [DATA_W-1:0] fb;
    } t_chain_ctl;

endpackage

// File: rtl/positional_array_list_top.sv
// -----------------------------------------------------------------------------
// Positional array list
// A rejected command strobes its result without turning the cell chain;
// any other command takes one full turn of the cell chain before its strobe.
// No new command is taken while a turn is under way (busy is high);
// the next command is taken in the strobe cycle. The receiver cannot stall.
// Reset empties the list and idles the controller; cell contents are kept.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_array_list_top
    import pal_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_opcode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [POS_W-1:0]         o_found_position,
    output logic [POS_W-1:0]         o_count
);

    t_chain_ctl        chain;
    logic [DATA_W-1:0] q [CAPACITY];
    logic [DATA_W-1:0] data_u;

    pal_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_head          (q[0]),
        .i_next          (q[1]),
        .o_chain         (chain),
        .o_busy          (busy),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_data          (data_u),
        .o_found_position(o_found_position),
        .o_count         (o_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_tail
            pal_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(chain.shift),
                .i_d    (chain.fb),
                .o_q    (q[g])
            );
        end else begin : g_body
            pal_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(chain.shift),
                .i_d    (q[g+1]),
                .o_q    (q[g])
            );
        end
    end

    assign o_data = data_u;

endmodule

// File: rtl/pal_cell.sv
// -----------------------------------------------------------------------------
// Positional array list storage cell
// Holds one list entry and takes its neighbor's entry on each shift.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pal_cell
    import pal_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_d,
    output logic [DATA_W-1:0] o_q
);

    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/pal_ctrl.sv
// -----------------------------------------------------------------------------
// Positional array list controller
// Checks each command; an accepted one rotates the cell chain once through the
// head and rewrites the feedback entry to insert, delete, read or search.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pal_ctrl
    import pal_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [1:0]               i_opcode,
    input  logic [POS_W-1:0]         i_position,
    input  logic [DATA_W-1:0]        i_value,
    input  logic [DATA_W-1:0]        i_head,
    input  logic [DATA_W-1:0]        i_next,
    output t_chain_ctl               o_chain,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [DATA_W-1:0]        o_data,
    output logic [POS_W-1:0]         o_found_position,
    output logic [POS_W-1:0]         o_count
);

    localparam int CW   = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int XW   = CNTW + POS_W + 1;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]     r_j, n_j;
    logic [CNTW-1:0]   r_count, n_count;
    logic [DATA_W-1:0] r_carry, n_carry;
    logic              r_hit, n_hit;
    logic [XW-1:0]     r_found, n_found;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic [POS_W-1:0]  r_fpos, n_fpos;

    logic [XW-1:0] jx, cx, pi, ix;
    logic [XW-1:0] cnt_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_j      <= n_j;
        r_carry  <= n_carry;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_status <= n_status;
        r_data   <= n_data;
        r_fpos   <= n_fpos;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_pos    = r_pos;
        n_val    = r_val;
        n_j      = r_j;
        n_count  = r_count;
        n_carry  = r_carry;
        n_hit    = r_hit;
        n_found  = r_found;
        n_done   = 1'b0;
        n_status = r_status;
        n_data   = r_data;
        n_fpos   = r_fpos;
        o_chain.shift = 1'b0;
        o_chain.fb    = i_head;

        jx = XW'(r_j);
        cx = XW'(r_count);
        pi = XW'(r_pos) - XW'(1);
        ix = XW'(i_position);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = t_op'(i_opcode);
                    n_pos    = i_position;
                    n_val    = i_value;
                    n_j      = '0;
                    n_hit    = 1'b0;
                    n_found  = '0;
                    n_data   = '0;
                    n_fpos   = '0;
                    n_status = ST_OK;
                    n_state  = S_PASS;
                    unique case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (ix == '0 || ix > cx + XW'(1)) begin
                                n_status = ST_BAD_POS;
                                n_done   = 1'b1;
                                n_state  = S_IDLE;
                            end else if (cx >= XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        OP_DELETE: begin
                            if (ix == '0 || ix > cx) begin
                                n_status = ST_BAD_POS;
                                n_done   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        OP_GET: begin
                            if (ix == '0 || ix > cx) begin
                                n_status = ST_BAD_POS;
                                n_data   = '1;
                                n_done   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        OP_LOCATE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PASS: begin
                o_chain.shift = 1'b1;
                n_carry       = i_head;
                unique case (r_op)
                    OP_INSERT: begin
                        if (jx < pi) begin
                            o_chain.fb = i_head;
                        end else if (jx == pi) begin
                            o_chain.fb = r_val;
                        end else begin
                            o_chain.fb = r_carry;
                        end
                    end
                    OP_DELETE: begin
                        o_chain.fb = (jx < pi) ? i_head : i_next;
                        if (jx == pi) begin
                            n_data = i_head;
                        end
                    end
                    OP_GET: begin
                        if (jx == pi) begin
                            n_data = i_head;
                        end
                    end
                    OP_LOCATE: begin
                        if (!r_hit && jx < cx && i_head == r_val) begin
                            n_hit   = 1'b1;
                            n_found = jx + XW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_j == CW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    unique case (r_op)
                        OP_INSERT: n_count = r_count + CNTW'(1);
                        OP_DELETE: n_count = r_count - CNTW'(1);
                        OP_GET:    n_count = r_count;
                        OP_LOCATE: begin
                            n_status = n_hit ? ST_OK : ST_NOT_FOUND;
                            n_fpos   = n_hit ? n_found[POS_W-1:0] : '0;
                        end
                        default:   n_count = r_count;
                    endcase
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cnt_x            = XW'(r_count);
    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_data           = r_data;
    assign o_found_position = r_fpos;
    assign o_count          = cnt_x[POS_W-1:0];

endmodule

// File: rtl/pal_checker.sv
// -----------------------------------------------------------------------------
// Positional array list port checker
// Watches the top-level ports for command and result consistency.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "positional_array_list_top_defines.svh"

module pal_checker
    import pal_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_done,
    input logic [1:0]               o_status,
    input logic signed [DATA_W-1:0] o_data,
    input logic [POS_W-1:0]         o_found_position
);

    logic done_nf;
    logic done_bp;
    logic nf_clean;
    logic bp_clean;

    assign done_nf  = o_done && (o_status == ST_NOT_FOUND);
    assign done_bp  = o_done && (o_status == ST_BAD_POS);
    assign nf_clean = (o_found_position == '0) && (o_data == '0);
    assign bp_clean = ((o_data == '0) || (o_data == '1)) && (o_found_position == '0);

    `PAL_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_done, "transaction lost")
    `PAL_ASSERT_NOW(a_done_idle, o_done, !busy, "result strobed while busy")
    `PAL_ASSERT_NOW(a_not_found, done_nf, nf_clean, "not-found result carries data")
    `PAL_ASSERT_NOW(a_bad_pos, done_bp, bp_clean, "bad-position result carries data")

endmodule

bind positional_array_list_top pal_checker u_pal_checker (.*);
